/* hdl/apb_pkg.sv */
// Package for the ARGB pixel blend unit: stage record types, register
// indexes, factor and operation codes, and the per-channel blend functions.
// No dependencies.
package apb_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SRC_FACTOR  = 3'd0,
    CFG_DST_FACTOR  = 3'd1,
    CFG_BLEND_OP    = 3'd2,
    CFG_TINT_ENABLE = 3'd3,
    CFG_TINT_COLOR  = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    FACTOR_ZERO          = 4'd0,
    FACTOR_ONE           = 4'd1,
    FACTOR_SRC_ALPHA     = 4'd2,
    FACTOR_INV_SRC_ALPHA = 4'd3,
    FACTOR_DST_ALPHA     = 4'd4,
    FACTOR_INV_DST_ALPHA = 4'd5,
    FACTOR_SRC_COLOR     = 4'd6,
    FACTOR_DST_COLOR     = 4'd7,
    FACTOR_INV_SRC_COLOR = 4'd8,
    FACTOR_INV_DST_COLOR = 4'd9
  } factor_t;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_SUBTRACT = 2'd1,
    OP_REV_SUB  = 2'd2,
    OP_KEEP_DST = 2'd3
  } blend_op_t;

  localparam logic [7:0] ChannelMax = 8'd255;

  typedef struct packed {
    logic [7:0]      src_alpha;
    logic [2:0][7:0] src_color;
    logic [7:0]      dst_alpha;
    logic [2:0][7:0] dst_color;
    logic            modified;
    logic            row_end;
  } tint_stage_t;

  typedef struct packed {
    logic [7:0]       alpha;
    logic [2:0][15:0] src_term;
    logic [2:0][15:0] dst_term;
    logic [2:0][7:0]  dst_color;
    logic             modified;
    logic             row_end;
  } term_stage_t;

  typedef struct packed {
    logic [7:0]      alpha;
    logic [2:0][7:0] color;
    logic            modified;
    logic            row_end;
  } out_stage_t;

  function automatic logic [7:0] pick_factor(logic [3:0] code, logic [7:0] sa,
                                             logic [7:0] da, logic [7:0] sc,
                                             logic [7:0] dc);
    logic [7:0] f;
    case (code)
      FACTOR_ZERO:          f = 8'd0;
      FACTOR_ONE:           f = ChannelMax;
      FACTOR_SRC_ALPHA:     f = sa;
      FACTOR_INV_SRC_ALPHA: f = ChannelMax - sa;
      FACTOR_DST_ALPHA:     f = da;
      FACTOR_INV_DST_ALPHA: f = ChannelMax - da;
      FACTOR_SRC_COLOR:     f = sc;
      FACTOR_DST_COLOR:     f = dc;
      FACTOR_INV_SRC_COLOR: f = ChannelMax - sc;
      FACTOR_INV_DST_COLOR: f = ChannelMax - dc;
      default:              f = ChannelMax;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] combine(logic [1:0] op, logic [15:0] st,
                                         logic [15:0] dt, logic [7:0] dc);
    logic [16:0] sum;
    logic [15:0] diff;
    logic [7:0]  v;
    sum  = {1'b0, st} + {1'b0, dt};
    diff = 16'd0;
    case (op)
      OP_ADD: begin
        v = sum[16] ? ChannelMax : sum[15:8];
      end
      OP_SUBTRACT: begin
        diff = st - dt;
        v = (st < dt) ? 8'd0 : diff[15:8];
      end
      OP_REV_SUB: begin
        diff = dt - st;
        v = (dt < st) ? 8'd0 : diff[15:8];
      end
      default: begin
        v = dc;
      end
    endcase
    return v;
  endfunction

endpackage

/* hdl/argb_pixel_blend_unit.sv */
// ARGB pixel blend unit: three-stage pipeline with a configuration register bank.
// A request passes in order through the tint, factor product and combine stage registers.
// Throughput is one pixel per cycle while out_stall does not hold the pipeline.
// Each stage holds only while the stage after it is full and held, so bubbles close up.
// Synchronous active-high reset clears the stage valid bits and loads the register
// defaults; pixel data registers are not reset. Depends on apb_pkg.
module argb_pixel_blend_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [apb_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [apb_pkg::CfgDataWidth-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          src_alpha,
  input  logic [7:0]                          src_red,
  input  logic [7:0]                          src_green,
  input  logic [7:0]                          src_blue,
  input  logic [7:0]                          dst_alpha,
  input  logic [7:0]                          dst_red,
  input  logic [7:0]                          dst_green,
  input  logic [7:0]                          dst_blue,
  input  logic                                row_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_alpha,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic                                modified,
  output logic                                row_end_out
);
  import apb_pkg::*;

  logic [3:0]  src_factor;
  logic [3:0]  dst_factor;
  logic [1:0]  blend_op;
  logic        tint_enable;
  logic [31:0] tint_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_factor  <= FACTOR_SRC_ALPHA;
      dst_factor  <= FACTOR_INV_SRC_ALPHA;
      blend_op    <= OP_ADD;
      tint_enable <= 1'b0;
      tint_color  <= 32'hFFFF_FFFF;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_SRC_FACTOR:  src_factor  <= cfg_data[3:0];
        CFG_DST_FACTOR:  dst_factor  <= cfg_data[3:0];
        CFG_BLEND_OP:    blend_op    <= cfg_data[1:0];
        CFG_TINT_ENABLE: tint_enable <= cfg_data[0];
        CFG_TINT_COLOR:  tint_color  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic        valid1, valid2, valid3;
  logic        ready1, ready2, ready3;
  tint_stage_t stage1, stage1_next;
  term_stage_t stage2, stage2_next;
  out_stage_t  stage3, stage3_next;

  assign ready3   = !valid3 || !out_stall;
  assign ready2   = !valid2 || ready3;
  assign ready1   = !valid1 || ready2;
  assign in_stall = !ready1;

  logic            tint_on;
  logic [3:0][7:0] src_in;
  logic [3:0][7:0] tint_ch;
  logic [3:0][15:0] tint_prod;

  assign tint_on = tint_enable && (tint_color[31:24] != 8'd0);
  assign src_in  = {src_alpha, src_red, src_green, src_blue};
  assign tint_ch = tint_color;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tint_prod[i] = {8'd0, src_in[i]} * {8'd0, tint_ch[i]};
    end
    stage1_next.src_alpha = tint_on ? tint_prod[3][15:8] : src_alpha;
    for (int i = 0; i < 3; i++) begin
      stage1_next.src_color[i] = tint_on ? tint_prod[i][15:8] : src_in[i];
    end
    stage1_next.dst_alpha = dst_alpha;
    stage1_next.dst_color = {dst_red, dst_green, dst_blue};
    stage1_next.modified  = (src_alpha != 8'd0);
    stage1_next.row_end   = row_end;
  end

  always_comb begin
    logic [7:0] fs;
    logic [7:0] fd;
    for (int i = 0; i < 3; i++) begin
      fs = pick_factor(src_factor, stage1.src_alpha, stage1.dst_alpha,
                       stage1.src_color[i], stage1.dst_color[i]);
      fd = pick_factor(dst_factor, stage1.src_alpha, stage1.dst_alpha,
                       stage1.src_color[i], stage1.dst_color[i]);
      stage2_next.src_term[i] = {8'd0, stage1.src_color[i]} * {8'd0, fs};
      stage2_next.dst_term[i] = {8'd0, stage1.dst_color[i]} * {8'd0, fd};
    end
    if (!stage1.modified) begin
      stage2_next.alpha = stage1.dst_alpha;
    end else begin
      stage2_next.alpha = (stage1.src_alpha > stage1.dst_alpha) ?
                          stage1.src_alpha : stage1.dst_alpha;
    end
    stage2_next.dst_color = stage1.dst_color;
    stage2_next.modified  = stage1.modified;
    stage2_next.row_end   = stage1.row_end;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      stage3_next.color[i] = stage2.modified ?
          combine(blend_op, stage2.src_term[i], stage2.dst_term[i],
                  stage2.dst_color[i]) :
          stage2.dst_color[i];
    end
    stage3_next.alpha    = stage2.alpha;
    stage3_next.modified = stage2.modified;
    stage3_next.row_end  = stage2.row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (ready1) valid1 <= in_valid;
      if (ready2) valid2 <= valid1;
      if (ready3) valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) stage1 <= stage1_next;
    if (ready2 && valid1)   stage2 <= stage2_next;
    if (ready3 && valid2)   stage3 <= stage3_next;
  end

  assign out_valid   = valid3;
  assign out_alpha   = stage3.alpha;
  assign out_red     = stage3.color[2];
  assign out_green   = stage3.color[1];
  assign out_blue    = stage3.color[0];
  assign modified    = stage3.modified;
  assign row_end_out = stage3.row_end;

  // The input side is held back only when every stage is full and the output waits.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (valid1 && valid2 && valid3 && out_stall))
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk) rst |=> !valid1 && !valid2 && !valid3)
    else $error("pipeline valid bits not cleared by reset");

  assert property (@(posedge clk) disable iff (rst)
    (valid2 && ready3) |=> valid3)
    else $error("request lost between the product and combine stages");

  assert property (@(posedge clk) disable iff (rst)
    (valid1 && !ready2) |=> valid1 && $stable(stage1))
    else $error("held tint stage changed");

endmodule
